// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the register server.
// Depends on nothing; compiled to empty text when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/mrs_pkg.sv =====
// Package of the register server: payload types, frame constants and the CRC step.
// Depends on nothing; used by mrs_frame_rx, mrs_reply and the top level.
package mrs_pkg;

	// Frame layout
	localparam int FRAME_LEN      = 8;
	localparam int STORED_LEN     = 6;
	localparam logic [2:0] LAST_POS = 3'(FRAME_LEN - 1);

	// Reply lengths in payload bytes, before the two CRC bytes
	localparam logic [2:0] READ_MSG_LEN  = 3'd5;
	localparam logic [2:0] WRITE_MSG_LEN = 3'd6;

	// CRC-16, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Function codes and reply constants
	localparam logic [7:0] FN_READ    = 8'h03;
	localparam logic [7:0] FN_WRITE   = 8'h06;
	localparam logic [7:0] READ_COUNT = 8'h02;

	// Defaults
	localparam int         REG_COUNT_DEF   = 16;
	localparam logic [7:0] SERVER_ADDR_RST = 8'h01;

	// Channel payloads
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} tx_rsp_t;

	typedef struct packed {
		logic [7:0] server_address;
	} cfg_req_t;

	// Accepted request handed from the receiver to the RAM and reply logic
	typedef struct packed {
		logic                             valid;
		logic                             is_write;
		logic [STORED_LEN-1:0][7:0]       bytes;
	} mrs_cmd_t;

	// Reply sequencer status
	typedef struct packed {
		logic busy;
	} mrs_rsp_status_t;

	// One byte through the CRC, bit by bit
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/mrs_stream_if.sv =====
// Valid/ready channel interface with a typed payload.
// Depends on nothing; payload types come from mrs_pkg at instantiation.
interface mrs_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/mrs_frame_rx.sv =====
// Request receiver: byte position, stored frame bytes, running CRC and request decode.
// Depends on mrs_pkg and mrs_stream_if.
module mrs_frame_rx
	import mrs_pkg::*;
#(
	parameter int REG_COUNT = REG_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mrs_stream_if.sink   rx,
	input  logic [7:0]   server_address,
	input  logic         hold,
	output mrs_cmd_t     cmd
);

	logic [2:0]  cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  frame_q [STORED_LEN];

	logic        acc;
	logic [2:0]  cnt_eff;
	logic [15:0] crc_eff;
	logic [15:0] crc_new;
	logic        frame_end;
	logic [15:0] reg_num;
	logic        in_range;
	logic        good;

	assign rx.ready = !hold;
	assign acc      = rx.valid && rx.ready;

	// Current byte position and CRC, restarted by a frame start mark
	always_comb begin
		cnt_eff   = rx.data.frame_start ? 3'd0 : cnt_q;
		crc_eff   = rx.data.frame_start ? CRC_INIT : crc_q;
		crc_new   = crc_feed(crc_eff, rx.data.rx_byte);
		frame_end = acc && (cnt_eff == LAST_POS);
	end

	// Decode on the last byte: CRC residue zero, our address, register in range, read or write function
	always_comb begin
		reg_num   = {frame_q[2], frame_q[3]};
		in_range  = {1'b0, reg_num} < 17'(REG_COUNT);
		good      = (crc_new == 16'h0000) && (frame_q[0] == server_address) && in_range;
		cmd.valid = frame_end && good && ((frame_q[1] == FN_READ) || (frame_q[1] == FN_WRITE));
		cmd.is_write = (frame_q[1] == FN_WRITE);
		for (int i = 0; i < STORED_LEN; i++) begin
			cmd.bytes[i] = frame_q[i];
		end
	end

	// Position and CRC; both restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			crc_q <= CRC_INIT;
		end else if (acc) begin
			cnt_q <= cnt_eff + 3'd1;
			crc_q <= (cnt_eff == LAST_POS) ? CRC_INIT : crc_new;
		end
	end

	// Header and data bytes of the frame
	always_ff @(posedge clk) begin
		for (int i = 0; i < STORED_LEN; i++) begin
			if (acc && (cnt_eff == 3'(i))) begin
				frame_q[i] <= rx.data.rx_byte;
			end
		end
	end

endmodule

// ===== rtl/mrs_reply.sv =====
// Reply sequencer: builds the read reply or write echo, appends the CRC, output register.
// Depends on mrs_pkg and mrs_stream_if.
module mrs_reply
	import mrs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  mrs_cmd_t        cmd,
	input  logic [15:0]     rdata,
	mrs_stream_if.source    tx,
	output mrs_rsp_status_t status
);

	logic                       busy_q;
	logic [2:0]                 idx_q;
	logic                       is_write_s1;
	logic [STORED_LEN-1:0][7:0] bytes_s1;
	logic [15:0]                crc_q;
	logic                       tx_valid_q;
	tx_rsp_t                    tx_data_q;

	logic       load;
	logic [2:0] msg_n;
	logic [7:0] msg_byte;
	logic       is_msg;
	logic       is_crc_lo;
	logic       last;
	logic [7:0] out_byte;

	assign status.busy = busy_q;
	assign tx.valid    = tx_valid_q;
	assign tx.data     = tx_data_q;

	// Next reply byte; register data stays in the RAM read register during the reply
	always_comb begin
		load      = busy_q && (!tx_valid_q || tx.ready);
		msg_n     = is_write_s1 ? WRITE_MSG_LEN : READ_MSG_LEN;
		case (idx_q)
			3'd0:    msg_byte = bytes_s1[0];
			3'd1:    msg_byte = bytes_s1[1];
			3'd2:    msg_byte = is_write_s1 ? bytes_s1[2] : READ_COUNT;
			3'd3:    msg_byte = is_write_s1 ? bytes_s1[3] : rdata[15:8];
			3'd4:    msg_byte = is_write_s1 ? bytes_s1[4] : rdata[7:0];
			3'd5:    msg_byte = bytes_s1[5];
			default: msg_byte = 8'h00;
		endcase
		is_msg    = idx_q < msg_n;
		is_crc_lo = idx_q == msg_n;
		last      = !is_msg && !is_crc_lo;
		out_byte  = is_msg ? msg_byte : (is_crc_lo ? crc_q[7:0] : crc_q[15:8]);
	end

	// Sequencer control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= 3'd0;
			tx_valid_q <= 1'b0;
		end else begin
			if (cmd.valid) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd0;
			end else if (load) begin
				idx_q <= idx_q + 3'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				tx_valid_q <= 1'b1;
			end else if (tx.ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, reply CRC and output byte
	always_ff @(posedge clk) begin
		if (cmd.valid) begin
			is_write_s1 <= cmd.is_write;
			bytes_s1    <= cmd.bytes;
			crc_q       <= CRC_INIT;
		end else if (load && is_msg) begin
			crc_q <= crc_feed(crc_q, msg_byte);
		end
		if (load) begin
			tx_data_q.tx_byte   <= out_byte;
			tx_data_q.last_byte <= last;
		end
	end

endmodule

// ===== rtl/modbus_rtu_register_server.sv =====
// Top level of the register server: config register, register file RAM and its clearing pass.
// Depends on mrs_pkg, mrs_stream_if, mrs_ram, mrs_frame_rx, mrs_reply, assert_macros.svh.
//
//  channel | dir | payload                      | accepted when
//  rx      | in  | rx_byte[7:0], frame_start    | rx.valid & rx.ready
//  tx      | out | tx_byte[7:0], last_byte      | tx.valid & tx.ready
//  cfg     | in  | server_address[7:0]          | cfg.valid & cfg.ready (always ready)
//
// Takes one request byte per cycle while no reply and no clearing pass is in progress.
// After the last byte of an answered request, rx stalls while the reply goes out:
// 7 bytes for a read, 8 for a write, one per cycle at best, longer under tx back-pressure.
// After reset the register file RAM is cleared one entry per cycle, and rx is held off until
// all REG_COUNT entries are cleared. The RAM has one write and one read port; a reply's register read
// is issued on the frame's last byte and its data stays in the RAM read register until the reply sends it.
`include "assert_macros.svh"

module modbus_rtu_register_server
	import mrs_pkg::*;
#(
	parameter int REG_COUNT = REG_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mrs_stream_if.sink   rx,
	mrs_stream_if.source tx,
	mrs_stream_if.sink   cfg
);

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	logic [7:0]      server_address_q;
	logic            clr_busy_q;
	logic [AW-1:0]   clr_idx_q;
	mrs_cmd_t        cmd;
	mrs_rsp_status_t status;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [15:0]     ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [15:0]     ram_rdata;
	logic [15:0]     reg_num;

	// Station address register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_address_q <= SERVER_ADDR_RST;
		end else if (cfg.valid && cfg.ready) begin
			server_address_q <= cfg.data.server_address;
		end
	end

	// Clearing pass over the register file after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(REG_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// RAM port control: clear, register write, register read
	always_comb begin
		reg_num   = {cmd.bytes[2], cmd.bytes[3]};
		ram_we    = clr_busy_q || (cmd.valid && cmd.is_write);
		ram_waddr = clr_busy_q ? clr_idx_q : reg_num[AW-1:0];
		ram_wdata = clr_busy_q ? 16'h0000 : {cmd.bytes[4], cmd.bytes[5]};
		ram_re    = cmd.valid && !cmd.is_write;
		ram_raddr = reg_num[AW-1:0];
	end

	mrs_ram #(
		.WIDTH (16),
		.DEPTH (REG_COUNT)
	) u_regfile (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mrs_frame_rx #(
		.REG_COUNT (REG_COUNT)
	) u_frame_rx (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx             (rx),
		.server_address (server_address_q),
		.hold           (clr_busy_q || status.busy),
		.cmd            (cmd)
	);

	mrs_reply u_reply (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rdata  (ram_rdata),
		.tx     (tx),
		.status (status)
	);

	// A request never arrives while the RAM is being cleared or a reply is running
	`ASSERT_IMPLY(a_cmd_idle, clk, arst_n, cmd.valid, !clr_busy_q && !status.busy, "busy at request")

	// No register read while the clearing pass owns the RAM
	`ASSERT_IMPLY(a_clr_no_read, clk, arst_n, clr_busy_q, !ram_re, "read during clear")

	// An answered request starts the reply sequencer
	`ASSERT_NEXT(a_cmd_starts_reply, clk, arst_n, cmd.valid, status.busy, "reply did not start")

endmodule
